// File: src/lfp_pkg.sv
// Package for the lidar frame parser: shared constants and the frame status struct.
// No dependencies; imported by lfp_frame_rx and lidar_frame_parser.
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFA;
    localparam logic [15:0] NO_RETURN_RAW  = 16'h8000;
    localparam int          FRAME_OVERHEAD = 6;

    localparam int BLK_W  = 5;
    localparam int SMP_W  = 5;
    localparam int SPD_W  = 16;
    localparam int DIST_W = 16;

    // Status of the frame parser toward the result sequencer. done is a
    // single-cycle pulse on the transfer of the final checksum byte; sum_ok is
    // valid only with done, and the other members hold until the next frame updates them.
    typedef struct packed {
        logic        done;
        logic        sum_ok;
        logic        emit;
        logic        new_scan;
        logic [7:0]  index;
        logic [15:0] speed;
    } t_frame_info;

endpackage

`default_nettype wire

// File: src/lfp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/lfp_frame_rx.sv
// Byte-level frame receiver: sync detection, header capture, running sum,
// sample writes into the sample RAM and the end-of-frame check. Uses lfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfp_frame_rx #(
    parameter int SAMPLES = 24,
    parameter int BLOCKS  = 30,
    parameter int AW      = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_byte,
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic [15:0]              o_wdata,
    output lfp_pkg::t_frame_info     o_info
);

    import lfp_pkg::*;

    localparam int FRAME_LEN = FRAME_OVERHEAD + 2 * SAMPLES;
    localparam int CW        = $clog2(FRAME_LEN);

    localparam logic [CW-1:0] P_INDEX  = CW'(1);
    localparam logic [CW-1:0] P_SPD_LO = CW'(2);
    localparam logic [CW-1:0] P_SPD_HI = CW'(3);
    localparam logic [CW-1:0] P_FIRST  = CW'(4);
    localparam logic [CW-1:0] P_SUM_LO = CW'(FRAME_LEN - 2);
    localparam logic [CW-1:0] P_SUM_HI = CW'(FRAME_LEN - 1);
    localparam logic [7:0]    LAST_BLK = 8'(BLOCKS - 1);

    logic          r_in_frame, n_in_frame;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_sum, n_sum;
    logic [7:0]    r_index, n_index;
    logic [15:0]   r_speed, n_speed;
    logic [7:0]    r_low, n_low;
    logic [7:0]    r_prev, n_prev;
    logic          r_new_scan, n_new_scan;

    logic          is_sync;
    logic          active;
    logic [CW-1:0] off;
    logic          done;
    logic          sum_ok;

    assign is_sync = (i_byte == SYNC_BYTE);
    assign active  = i_accept && !is_sync && r_in_frame;
    assign off     = r_count - P_FIRST;
    assign done    = active && (r_count == P_SUM_HI);
    assign sum_ok  = ({i_byte, r_low} == r_sum);

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_sum      = r_sum;
        n_index    = r_index;
        n_speed    = r_speed;
        n_low      = r_low;
        n_prev     = r_prev;
        n_new_scan = r_new_scan;
        o_we       = 1'b0;
        if (i_accept && is_sync) begin
            n_in_frame = 1'b1;
            n_count    = CW'(1);
            n_sum      = 16'(SYNC_BYTE);
        end else if (active) begin
            if (r_count < P_SUM_LO) begin
                n_sum = r_sum + 16'(i_byte);
            end
            if (r_count == P_INDEX) begin
                n_index = i_byte;
            end else if (r_count == P_SPD_LO) begin
                n_low = i_byte;
            end else if (r_count == P_SPD_HI) begin
                n_speed = {i_byte, r_low};
            end else if (r_count < P_SUM_LO) begin
                if (!off[0]) begin
                    n_low = i_byte;
                end else begin
                    o_we = 1'b1;
                end
            end else if (r_count == P_SUM_LO) begin
                n_low = i_byte;
            end
            n_count = r_count + CW'(1);
            if (done) begin
                n_in_frame = 1'b0;
                n_count    = '0;
                if (sum_ok) begin
                    n_new_scan = (r_index < r_prev);
                    n_prev     = r_index;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_sum      <= '0;
            r_index    <= '0;
            r_speed    <= '0;
            r_low      <= '0;
            r_prev     <= '0;
            r_new_scan <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_index    <= n_index;
            r_speed    <= n_speed;
            r_low      <= n_low;
            r_prev     <= n_prev;
            r_new_scan <= n_new_scan;
        end
    end

    assign o_waddr = AW'(off >> 1);
    assign o_wdata = {i_byte, r_low};

    assign o_info.done     = done;
    assign o_info.sum_ok   = sum_ok;
    assign o_info.emit     = (r_index <= LAST_BLK);
    assign o_info.new_scan = r_new_scan;
    assign o_info.index    = r_index;
    assign o_info.speed    = r_speed;

endmodule

`default_nettype wire

// File: src/lidar_frame_parser.sv
// Top level of the lidar frame parser: stream ports, result sequencer and output
// register. Depends on lfp_pkg, lfp_ram and lfp_frame_rx.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The slave channel takes one serial byte per transfer in i_s_axis_tdata. A
// byte of 0xFA starts a frame at any point, dropping a partial one. The
// distances of a frame are written into a sample RAM as their high bytes
// arrive; all other frame state sits in registers of the receiver.
// When the final checksum byte is taken the frame is judged. A bad sum gives
// one error transfer (tuser high, tlast high). A good frame whose block index
// is within the scan gives SAMPLES_PER_BLOCK sample transfers, the last with
// tlast high; a good frame beyond the scan gives nothing.
// Throughput: header and sample bytes are taken one per cycle while the
// sequencer is idle. After the checksum byte, the sequencer reads the sample
// RAM one entry per cycle while the output register is free. The input is
// held off (tready low) only while results of the current frame remain to be
// loaded into the output register, so the next byte is accepted while the
// last result still waits. When the frame has results, the sequencer leaves
// idle on the transfer of the checksum byte, and the first result is loaded
// into the output register once that register is free.
// A stall on the master side holds the output register and the RAM read
// address, so the drain simply pauses.
// Reset (synchronous, active low) clears the frame receiver, the sequencer
// and the output valid flag; the sample RAM needs no clearing, since each
// entry is written within a frame before that frame reads it.

module lidar_frame_parser #(
    parameter int SAMPLES_PER_BLOCK = 24,
    parameter int BLOCKS_PER_SCAN   = 30
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // [4:0] block_index, [9:5] sample_index,
                                               // [25:10] speed, [41:26] distance_mm,
                                               // [42] no_return, [43] new_scan,
                                               // [44] scan_end, [47:45] zero
    output logic             o_m_axis_tuser,   // [0] status
    output logic             o_m_axis_tlast    // last
);

    import lfp_pkg::*;

    localparam int AW = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(SAMPLES_PER_BLOCK - 1);
    localparam logic [7:0]    LAST_BLK = 8'(BLOCKS_PER_SCAN - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;

    logic          in_accept;
    logic          out_free;
    logic          load;
    logic          final_smp;
    t_frame_info   info;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    logic          r_out_valid;
    logic          r_status;
    logic [BLK_W-1:0]  r_blk;
    logic [SMP_W-1:0]  r_smp;
    logic [SPD_W-1:0]  r_spd;
    logic [DIST_W-1:0] r_dist;
    logic          r_nr, r_ns, r_se, r_last;

    logic          nr;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign load            = out_free && (r_state != ST_IDLE);
    assign final_smp       = (r_idx == LAST_IDX);

    lfp_frame_rx #(
        .SAMPLES (SAMPLES_PER_BLOCK),
        .BLOCKS  (BLOCKS_PER_SCAN),
        .AW      (AW)
    ) u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_axis_tdata),
        .o_we     (ram_we),
        .o_waddr  (ram_waddr),
        .o_wdata  (ram_wdata),
        .o_info   (info)
    );

    // The read address runs one ahead whenever a sample other than the last is
    // loaded, so the registered RAM output always belongs to the current index.
    assign ram_raddr = (r_state == ST_DRAIN && load && !final_smp) ? r_idx + AW'(1) : r_idx;

    lfp_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLES_PER_BLOCK),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: idle while bytes flow, a single error result on a bad sum, one
    // sample per free output slot while draining.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (info.done) begin
                    if (!info.sum_ok) begin
                        n_state = ST_ERR;
                    end else if (info.emit) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_ERR: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (load) begin
                    if (final_smp) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign nr = (ram_rdata == NO_RETURN_RAW);

    // Output register: valid is control state, the payload loads without reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_state == ST_ERR) begin
                r_status <= 1'b1;
                r_blk    <= '0;
                r_smp    <= '0;
                r_spd    <= '0;
                r_dist   <= '0;
                r_nr     <= 1'b0;
                r_ns     <= 1'b0;
                r_se     <= 1'b0;
                r_last   <= 1'b1;
            end else begin
                r_status <= 1'b0;
                r_blk    <= BLK_W'(info.index);
                r_smp    <= SMP_W'(r_idx);
                r_spd    <= info.speed;
                r_dist   <= nr ? '0 : ram_rdata;
                r_nr     <= nr;
                r_ns     <= (r_idx == '0) && info.new_scan;
                r_se     <= final_smp && (info.index == LAST_BLK);
                r_last   <= final_smp;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_se, r_ns, r_nr, r_dist, r_spd, r_smp, r_blk};
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tlast  = r_last;

    // A frame can only complete while the sequencer is idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        info.done |-> (r_state == ST_IDLE))
        else $error("frame completed while results were pending");

    // The drain index never leaves the sample RAM.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_idx <= LAST_IDX))
        else $error("drain index out of range");

    // An error result is always the only and final result of its frame.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("error result without tlast");

    // A bad checksum leads straight to the error state.
    a_err_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (info.done && !info.sum_ok) |=> (r_state == ST_ERR))
        else $error("bad checksum did not raise an error result");

endmodule

`default_nettype wire
